FILE: hw/rtl/stochastic_calcium_cluster_step_macros.svh
// Assertion macros for the calcium cluster step block
`ifndef STOCHASTIC_CALCIUM_CLUSTER_STEP_MACROS_SVH
`define STOCHASTIC_CALCIUM_CLUSTER_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define SCS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SCS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SCS_ASSERT(lbl, prop, msg)
`define SCS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/scs_pkg.sv
`timescale 1ns / 1ps
package scs_pkg;

   localparam int NUM_CLUSTERS_DEF = 10;
   localparam int MAX_CHANNELS_DEF = 15;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_OPEN_SCALE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REFR_PROB  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CLOSE_PROB = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REFR_NUM   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CA_REST    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CA_THRESH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LEAK       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_PUFF       = 3'd7;

   localparam logic [23:0] OPEN_SCALE_RST = 24'd16777;
   localparam logic [23:0] REFR_PROB_RST  = 24'd335544;
   localparam logic [23:0] CLOSE_PROB_RST = 24'd838861;
   localparam logic [3:0]  REFR_NUM_RST   = 4'd3;
   localparam logic [23:0] CA_REST_RST    = 24'd13107;
   localparam logic [23:0] CA_THRESH_RST  = 24'd32768;
   localparam logic [23:0] LEAK_RST       = 24'd16777;
   localparam logic [23:0] PUFF_RST       = 24'd655;

   localparam logic [5:0] DIV_STEPS = 6'd42;

   typedef enum logic [3:0] {
      ST_IDLE, ST_UPDATE, ST_LEAK, ST_SUM, ST_SQUARE, ST_CUBE,
      ST_DIV_LOAD, ST_DIV, ST_SCALE, ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic leak;
      logic sum;
      logic square;
      logic cube;
      logic div_load;
      logic div_step;
      logic scale;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last_item;
      logic div_last;
      logic rsp_full;
   } sts_type;

endpackage

FILE: hw/rtl/scs_ctrl.sv
`timescale 1ns / 1ps
`include "stochastic_calcium_cluster_step_macros.svh"
module scs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  scs_pkg::sts_type  sts,
   output scs_pkg::cmd_type  cmd
);
   scs_pkg::state_type st_ff, st_in;
   logic emit_ff, emit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= scs_pkg::ST_SQUARE;
         emit_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         emit_ff <= emit_in;
      end
   end

   always_comb begin
      st_in      = st_ff;
      emit_in    = emit_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (st_ff)
         scs_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) st_in = scs_pkg::ST_UPDATE;
         end
         scs_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            if (sts.last_item) begin
               st_in   = scs_pkg::ST_LEAK;
               emit_in = 1'b1;
            end else begin
               st_in = scs_pkg::ST_IDLE;
            end
         end
         scs_pkg::ST_LEAK: begin
            cmd.leak = 1'b1;
            st_in    = scs_pkg::ST_SUM;
         end
         scs_pkg::ST_SUM: begin
            cmd.sum = 1'b1;
            st_in   = scs_pkg::ST_SQUARE;
         end
         scs_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
            st_in      = scs_pkg::ST_CUBE;
         end
         scs_pkg::ST_CUBE: begin
            cmd.cube = 1'b1;
            st_in    = scs_pkg::ST_DIV_LOAD;
         end
         scs_pkg::ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            st_in        = scs_pkg::ST_DIV;
         end
         scs_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) st_in = scs_pkg::ST_SCALE;
         end
         scs_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            st_in     = emit_ff ? scs_pkg::ST_EMIT : scs_pkg::ST_IDLE;
         end
         scs_pkg::ST_EMIT: begin
            if (!sts.rsp_full) begin
               cmd.emit = 1'b1;
               emit_in  = 1'b0;
               st_in    = scs_pkg::ST_IDLE;
            end
         end
         default: st_in = scs_pkg::ST_IDLE;
      endcase
   end

   `SCS_ASSERT(a_update_next, (st_ff == scs_pkg::ST_UPDATE) |=> (st_ff == scs_pkg::ST_IDLE || st_ff == scs_pkg::ST_LEAK), "bad state after update")
   `SCS_ASSERT(a_init_no_emit, (st_ff == scs_pkg::ST_SCALE && !emit_ff) |=> (st_ff == scs_pkg::ST_IDLE), "start-up pass emitted")
   `SCS_ASSERT(a_emit_done, (st_ff == scs_pkg::ST_EMIT && !sts.rsp_full) |=> (st_ff == scs_pkg::ST_IDLE && !emit_ff), "emit not completed")
endmodule

FILE: hw/rtl/scs_dp.sv
`timescale 1ns / 1ps
module scs_dp #(
   parameter int NUM_CLUSTERS = scs_pkg::NUM_CLUSTERS_DEF,
   parameter int MAX_CHANNELS = scs_pkg::MAX_CHANNELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [scs_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tlast,
   input  logic                              csr_we,
   input  logic [scs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [scs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [scs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tuser,
   input  scs_pkg::cmd_type                  cmd,
   output scs_pkg::sts_type                  sts
);
   localparam int IDX_W = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
   localparam logic [3:0] MAX_CH = 4'(MAX_CHANNELS);
   localparam logic [6:0] NUM_CL = 7'(NUM_CLUSTERS);

   logic [23:0] open_scale_ff, refr_prob_ff, close_prob_ff, ca_rest_ff;
   logic [23:0] ca_thresh_ff, leak_coeff_ff, puff_ff;
   logic [3:0]  refr_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_scale_ff <= scs_pkg::OPEN_SCALE_RST;
         refr_prob_ff  <= scs_pkg::REFR_PROB_RST;
         close_prob_ff <= scs_pkg::CLOSE_PROB_RST;
         refr_num_ff   <= scs_pkg::REFR_NUM_RST;
         ca_rest_ff    <= scs_pkg::CA_REST_RST;
         ca_thresh_ff  <= scs_pkg::CA_THRESH_RST;
         leak_coeff_ff <= scs_pkg::LEAK_RST;
         puff_ff       <= scs_pkg::PUFF_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            scs_pkg::REG_OPEN_SCALE: open_scale_ff <= csr_wdata;
            scs_pkg::REG_REFR_PROB:  refr_prob_ff  <= csr_wdata;
            scs_pkg::REG_CLOSE_PROB: close_prob_ff <= csr_wdata;
            scs_pkg::REG_REFR_NUM:   refr_num_ff   <= csr_wdata[3:0];
            scs_pkg::REG_CA_REST:    ca_rest_ff    <= csr_wdata;
            scs_pkg::REG_CA_THRESH:  ca_thresh_ff  <= csr_wdata;
            scs_pkg::REG_LEAK:       leak_coeff_ff <= csr_wdata;
            scs_pkg::REG_PUFF:       puff_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // captured item
   logic [23:0] rnd_ff;
   logic [3:0]  draw_ff;
   logic [5:0]  idx_ff;
   logic        last_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rnd_ff  <= req_tdata[23:0];
         draw_ff <= req_tdata[27:24];
         idx_ff  <= req_tdata[33:28];
         last_ff <= req_tlast;
      end
   end

   // cluster update
   logic signed [4:0] cs_ff [NUM_CLUSTERS];
   logic [9:0]  total_ff;
   logic [23:0] prob_ff;
   logic [IDX_W-1:0] idx_w;
   logic        idx_ok;
   logic signed [4:0] old_s, new_s;
   logic [3:0]  draw_sat, refr_n;
   logic [9:0]  old_pos, new_pos;

   always_comb begin
      idx_ok   = {1'b0, idx_ff} < NUM_CL;
      idx_w    = idx_ff[IDX_W-1:0];
      old_s    = idx_ok ? cs_ff[idx_w] : 5'sd0;
      draw_sat = (draw_ff == 4'd0) ? 4'd1 : ((draw_ff > MAX_CH) ? MAX_CH : draw_ff);
      refr_n   = (refr_num_ff == 4'd0) ? 4'd1 : refr_num_ff;
      new_s    = old_s;
      if (old_s < 0) begin
         if (rnd_ff < refr_prob_ff) new_s = old_s + 5'sd1;
      end else if (old_s == 0) begin
         if (rnd_ff < prob_ff) new_s = signed'({1'b0, draw_sat});
      end else if (rnd_ff < close_prob_ff) begin
         new_s = (old_s == 5'sd1) ? signed'(5'd1 - {1'b0, refr_n}) : old_s - 5'sd1;
      end
      old_pos = (old_s > 0) ? {6'd0, old_s[3:0]} : 10'd0;
      new_pos = (new_s > 0) ? {6'd0, new_s[3:0]} : 10'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLUSTERS; i++) cs_ff[i] <= 5'sd0;
         total_ff <= 10'd0;
      end else if (cmd.update && idx_ok) begin
         cs_ff[idx_w] <= new_s;
         total_ff     <= total_ff - old_pos + new_pos;
      end
   end

   // step end arithmetic
   logic [23:0] ca_ff;
   logic [47:0] leak_prod_ff;
   logic        leak_neg_ff;
   logic [33:0] puff_prod_ff;
   logic [24:0] diff, mag25;
   logic [24:0] leak_amt;
   logic signed [36:0] ca_sum;

   always_comb begin
      diff     = {1'b0, ca_ff} - {1'b0, ca_rest_ff};
      mag25    = diff[24] ? (25'd0 - diff) : diff;
      leak_amt = 25'((leak_prod_ff + 48'd8388608) >> 24);
      ca_sum   = signed'({13'd0, ca_ff}) + signed'({3'd0, puff_prod_ff});
      if (leak_neg_ff) ca_sum = ca_sum + signed'({12'd0, leak_amt});
      else             ca_sum = ca_sum - signed'({12'd0, leak_amt});
   end

   always_ff @(posedge clock) begin
      if (cmd.leak) begin
         leak_prod_ff <= mag25[23:0] * leak_coeff_ff;
         leak_neg_ff  <= diff[24];
         puff_prod_ff <= total_ff * puff_ff;
      end
   end

   // opening probability: cube, iterative divide, scale
   logic [31:0] sq_ff;
   logic [39:0] c3_ff;
   logic [40:0] den_ff;
   logic [41:0] num_ff;
   logic [40:0] rem_ff;
   logic [24:0] q_ff;
   logic [5:0]  cnt_ff;
   logic [41:0] trial;
   logic        fits;
   logic [40:0] den_c;
   logic [24:0] ratio;
   logic [48:0] scaled;
   logic [47:0] sq_full;
   logic [55:0] cube_full;

   always_comb begin
      trial     = {rem_ff, num_ff[41]};
      fits      = trial >= {1'b0, den_ff};
      den_c     = 41'd65536 + {1'b0, c3_ff};
      ratio     = 25'd16777216 - q_ff;
      scaled    = open_scale_ff * ratio;
      sq_full   = {24'd0, ca_ff} * {24'd0, ca_ff};
      cube_full = {24'd0, sq_ff} * {32'd0, ca_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.square) sq_ff <= sq_full[47:16];
      if (cmd.cube)   c3_ff <= cube_full[55:16];
      if (cmd.div_load) begin
         den_ff <= den_c;
         num_ff <= 42'h100_0000_0000 + {1'b0, den_c} - 42'd1;
         rem_ff <= '0;
         q_ff   <= '0;
         cnt_ff <= scs_pkg::DIV_STEPS;
      end else if (cmd.div_step) begin
         rem_ff <= fits ? 41'(trial - {1'b0, den_ff}) : trial[40:0];
         num_ff <= {num_ff[40:0], 1'b0};
         q_ff   <= {q_ff[23:0], fits};
         cnt_ff <= cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prob_ff <= '0;
      end else if (cmd.scale) begin
         prob_ff <= scaled[47:24];
      end
   end

   // calcium and result register
   logic        rsp_valid_ff;
   logic [9:0]  rsp_open_ff;
   logic [23:0] rsp_ca_ff;
   logic        rsp_spike_ff;
   logic        spike;

   assign spike = ca_ff >= ca_thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ca_ff <= scs_pkg::CA_REST_RST;
      end else if (cmd.sum) begin
         if (ca_sum < 0)                             ca_ff <= '0;
         else if (ca_sum > signed'(37'hFF_FFFF))     ca_ff <= 24'hFF_FFFF;
         else                                        ca_ff <= ca_sum[23:0];
      end else if (cmd.emit && spike) begin
         ca_ff <= ca_rest_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_open_ff  <= total_ff;
         rsp_ca_ff    <= spike ? ca_rest_ff : ca_ff;
         rsp_spike_ff <= spike;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {6'd0, rsp_ca_ff, rsp_open_ff};
   assign rsp_tuser    = rsp_spike_ff;
   assign sts.last_item = last_ff;
   assign sts.div_last  = cnt_ff == 6'd1;
   assign sts.rsp_full  = rsp_valid_ff && !rsp_tready;
endmodule

FILE: hw/rtl/stochastic_calcium_cluster_step.sv
`timescale 1ns / 1ps
// Stochastic calcium cluster step.
// req_ carries one cluster update per transfer; req_tlast marks the last
// cluster of a time step. Only that transfer produces a rsp_ transfer with
// the step's open channel total, the new calcium level and (tuser) spike.
// csr_ writes one of eight registers per cycle; the user must write only
// while the block is idle, which the block itself does not enforce.
// An ordinary cluster update is a capture, then one read-modify-write of
// the cluster state register file. A step-end item raises rsp_tvalid
// after leak and puff products, saturating sum, square, cube, a
// one-bit-per-cycle divider for the opening probability, the scale and
// the emit; req_tready stays low until the result is emitted.
// After reset the opening probability is computed from resting calcium in
// a start-up pass, during which req_tready stays low.
// The result sits in an output register; if rsp_tready is low, cluster
// updates still proceed, and the next step end waits for the slot.
module stochastic_calcium_cluster_step #(
   parameter int NUM_CLUSTERS = scs_pkg::NUM_CLUSTERS_DEF,
   parameter int MAX_CHANNELS = scs_pkg::MAX_CHANNELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // rand_fraction[23:0], open_draw[27:24], cluster_index[33:28]
   input  logic [scs_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // open_channels[9:0], calcium_level[33:10]
   output logic [scs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // spike[0]
   output logic                            rsp_tuser,
   input  logic                            csr_we,
   input  logic [scs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [scs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   scs_pkg::cmd_type cmd;
   scs_pkg::sts_type sts;

   scs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   scs_dp #(
      .NUM_CLUSTERS (NUM_CLUSTERS),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );
endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;

   localparam int NCL      = scs_pkg::NUM_CLUSTERS_DEF;
   localparam int SETTLE   = 80;
   localparam int WD_LIMIT = 3000;

   typedef struct {
      logic [9:0]  open_total;
      logic [23:0] ca_level;
      logic        spike;
   } step_result_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [scs_pkg::REQ_DATA_W-1:0]  req_tdata;
   logic                            req_tlast;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [scs_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_we;
   logic [scs_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [scs_pkg::CSR_DATA_W-1:0]  csr_wdata;

   logic [23:0]      cfg [8];
   int               cluster_state [NCL];
   logic [23:0]      ca_now;
   logic [23:0]      p_open;
   step_result_type  step_results [$];
   int               errors;
   int               n_items;
   int               n_steps;
   int               n_spikes;
   int               stall;
   int               idle_cycles;
   bit               quiet;

   stochastic_calcium_cluster_step u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [23:0] open_prob(logic [23:0] c);
      longint unsigned cc, c2, c3, den, q, ratio, scale;
      cc    = c;
      c2    = (cc * cc) >> 16;
      c3    = (c2 * cc) >> 16;
      den   = 64'd65536 + c3;
      q     = ((64'd1 << 40) + den - 1) / den;
      ratio = (64'd1 << 24) - q;
      scale = cfg[scs_pkg::REG_OPEN_SCALE];
      return 24'((scale * ratio) >> 24);
   endfunction

   task automatic update_cluster(logic [23:0] r, logic [3:0] draw, logic [5:0] idx, bit last);
      int s, n, total;
      longint diff, mag, leak, cav;
      step_result_type res;
      if (idx < NCL) begin
         s = cluster_state[idx];
         if (s < 0) begin
            if (r < cfg[scs_pkg::REG_REFR_PROB]) cluster_state[idx] = s + 1;
         end else if (s == 0) begin
            if (r < p_open) cluster_state[idx] = (draw == 4'd0) ? 1 : int'(draw);
         end else if (r < cfg[scs_pkg::REG_CLOSE_PROB]) begin
            if (s != 1) begin
               cluster_state[idx] = s - 1;
            end else begin
               n = int'(cfg[scs_pkg::REG_REFR_NUM][3:0]);
               if (n < 1) n = 1;
               cluster_state[idx] = -(n - 1);
            end
         end
      end
      if (!last) return;
      total = 0;
      for (int i = 0; i < NCL; i++)
         if (cluster_state[i] > 0) total += cluster_state[i];
      diff = longint'(ca_now) - longint'(cfg[scs_pkg::REG_CA_REST]);
      mag  = (diff < 0) ? -diff : diff;
      mag  = (mag * longint'(cfg[scs_pkg::REG_LEAK]) + (64'sd1 <<< 23)) >>> 24;
      leak = (diff < 0) ? -mag : mag;
      cav  = longint'(ca_now) - leak + longint'(total) * longint'(cfg[scs_pkg::REG_PUFF]);
      if (cav < 0) cav = 0;
      if (cav > 64'sd16777215) cav = 64'sd16777215;
      ca_now = cav[23:0];
      p_open = open_prob(ca_now);
      res.spike = 1'b0;
      if (ca_now >= cfg[scs_pkg::REG_CA_THRESH]) begin
         ca_now    = cfg[scs_pkg::REG_CA_REST];
         res.spike = 1'b1;
      end
      res.open_total = total[9:0];
      res.ca_level   = ca_now;
      step_results.insert(step_results.size(), res);
   endtask

   // called just after a rising edge
   task automatic send_item(logic [23:0] r, logic [3:0] draw, logic [5:0] idx, bit last);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, idx, draw, r};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      update_cluster(r, draw, idx, last);
      n_items++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (step_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_regs(logic [23:0] v [8]);
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= i[2:0];
         csr_wdata <= v[i];
         @(posedge clock);
         cfg[i] = (i == scs_pkg::REG_REFR_NUM) ? {20'd0, v[i][3:0]} : v[i];
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [23:0] pick_r();
      case ($urandom_range(0, 2))
         0: return 24'($urandom);
         1: return 24'($urandom_range(0, 24'h0FFFFF));
         default: return 24'($urandom_range(0, 24'h3FFFFF));
      endcase
   endfunction

   task automatic run_steps(int nsteps, int noise_pct);
      for (int s = 0; s < nsteps; s++) begin
         for (int c = 0; c < NCL; c++) begin
            if ($urandom_range(0, 99) < noise_pct)
               send_item(24'($urandom), 4'($urandom), 6'($urandom), $urandom_range(0, 5) == 0);
            send_item(pick_r(), 4'($urandom), 6'(c), c == NCL - 1);
         end
      end
   endtask

   task automatic test_directed();
      logic [23:0] v [8];
      // wide open: everything moves, calcium pegs high
      v = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0, 24'hFFFFFF, 24'hFFFFFF,
            24'hFFFFFF};
      write_regs(v);
      send_item(24'd0, 4'd0, 6'd0, 1'b0);
      send_item(24'hFFFFFF, 4'd15, 6'd1, 1'b0);
      send_item(24'd0, 4'd15, 6'd2, 1'b0);
      send_item(24'd0, 4'd7, 6'd10, 1'b0);
      send_item(24'd0, 4'd7, 6'd63, 1'b1);
      send_item(24'd0, 4'd1, 6'd0, 1'b0);
      send_item(24'd0, 4'd1, 6'd2, 1'b0);
      send_item(24'd0, 4'd15, 6'd9, 1'b0);
      send_item(24'd0, 4'd15, 6'd1, 1'b1);
      send_item(24'hFFFFFF, 4'd3, 6'd63, 1'b1);
      drain();
      // deep refractory, spike every step, rest at top
      v = '{24'hFFFFFF, 24'd1, 24'hFFFFFF, 24'd15, 24'hFFFFFF, 24'd0, 24'd0, 24'd0};
      write_regs(v);
      send_item(24'd0, 4'd15, 6'd9, 1'b0);
      for (int k = 0; k < 16; k++) send_item(24'd0, 4'd2, 6'd9, 1'b0);
      send_item(24'd0, 4'd2, 6'd9, 1'b1);
      send_item(24'd0, 4'd2, 6'd5, 1'b1);
      drain();
   endtask

   task automatic test_random();
      logic [23:0] v [8];
      for (int ph = 0; ph < 6; ph++) begin
         for (int i = 0; i < 8; i++) begin
            case ($urandom_range(0, 3))
               0: v[i] = 24'd0;
               1: v[i] = 24'hFFFFFF;
               default: v[i] = 24'($urandom);
            endcase
         end
         v[scs_pkg::REG_REFR_NUM] = 24'($urandom_range(0, 15));
         if ($urandom_range(0, 1)) v[scs_pkg::REG_CA_REST] = 24'($urandom_range(0, 24'h01FFFF));
         if ($urandom_range(0, 1))
            v[scs_pkg::REG_CA_THRESH] = 24'($urandom_range(0, 24'h07FFFF));
         if ($urandom_range(0, 1)) v[scs_pkg::REG_PUFF] = 24'($urandom_range(0, 24'h00FFFF));
         if (ph == 0) v[scs_pkg::REG_OPEN_SCALE] = 24'hFFFFFF;
         write_regs(v);
         run_steps(5, 10);
         // sender holds off until every step result is back
         drain();
         run_steps(5, 10);
         drain();
      end
   endtask

   task automatic test_no_idle();
      quiet = 1'b1;
      run_steps(4, 5);
      drain();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall = 0;
      end else if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (stall > 0) begin
         stall--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall = $urandom_range(1, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      step_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (step_results.size() == 0) begin
            $display("%0t: unexpected result transfer %h", $time, rsp_tdata);
            errors++;
         end else begin
            exp_r = step_results.pop_front();
            n_steps++;
            if (rsp_tuser) n_spikes++;
            if (rsp_tdata[9:0] !== exp_r.open_total) begin
               $display("%0t: open_channels expected %0d actual %0d", $time,
                        exp_r.open_total, rsp_tdata[9:0]);
               errors++;
            end
            if (rsp_tdata[33:10] !== exp_r.ca_level) begin
               $display("%0t: calcium_level expected %h actual %h", $time,
                        exp_r.ca_level, rsp_tdata[33:10]);
               errors++;
            end
            if (rsp_tuser !== exp_r.spike) begin
               $display("%0t: spike expected %0b actual %0b", $time, exp_r.spike, rsp_tuser);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WD_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, WD_LIMIT);
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      quiet      = 1'b0;
      errors     = 0;
      n_items    = 0;
      n_steps    = 0;
      n_spikes   = 0;
      cfg[scs_pkg::REG_OPEN_SCALE] = scs_pkg::OPEN_SCALE_RST;
      cfg[scs_pkg::REG_REFR_PROB]  = scs_pkg::REFR_PROB_RST;
      cfg[scs_pkg::REG_CLOSE_PROB] = scs_pkg::CLOSE_PROB_RST;
      cfg[scs_pkg::REG_REFR_NUM]   = {20'd0, scs_pkg::REFR_NUM_RST};
      cfg[scs_pkg::REG_CA_REST]    = scs_pkg::CA_REST_RST;
      cfg[scs_pkg::REG_CA_THRESH]  = scs_pkg::CA_THRESH_RST;
      cfg[scs_pkg::REG_LEAK]       = scs_pkg::LEAK_RST;
      cfg[scs_pkg::REG_PUFF]       = scs_pkg::PUFF_RST;
      for (int i = 0; i < NCL; i++) cluster_state[i] = 0;
      ca_now = scs_pkg::CA_REST_RST;
      p_open = open_prob(ca_now);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // start-up pass keeps req_tready low
      while (!req_tready) @(posedge clock);
      run_steps(2, 0);
      drain();
      test_directed();
      test_random();
      test_no_idle();
      $display("covered %0d cluster transfers, %0d step results, %0d spikes", n_items,
               n_steps, n_spikes);
      $display("configs: defaults, extremes, six random phases, final stretch without stalls");
      if (errors == 0 && step_results.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule
